// File: rtl/core/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer: request and status
// codes, field widths and the register map.
// ----------------------------------------------------------------------------
package brb_pkg;

	// Fixed widths of the stream fields
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 10;
	localparam int RLEN_W  = 11;
	localparam int POFF_W  = 10;
	localparam int ADV_W   = 11;
	localparam int SIZE_W  = 4;

	// Register map: word select taken from paddr[2]
	localparam logic REG_SIZE_LOG2 = 1'b0;

	// Reset value of the size register
	localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;

	// Request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_PEEK    = 2'd1,
		REQ_ADVANCE = 2'd2
	} req_t;

	// Result status carried on the output tuser
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_INVALID  = 2'd2
	} status_t;

endpackage

// File: rtl/core/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Byte store of the ring: one write port and one read port, with the read
// data registered. The read register holds while rd_en is low.
// ----------------------------------------------------------------------------
module brb_ram
	import brb_pkg::*;
#(
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/byte_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_core
// Byte ring buffer with a power-of-two size in use, fed by a request stream
// and answering every request with one status and count transfer.
// ----------------------------------------------------------------------------
// The block takes one request transfer per clock cycle while the result side
// is not stalled, and returns one result transfer per request: the request is
// captured in an input register, evaluated combinationally against the head
// and tail pointers, and the result is held in an output register together with
// the registered read of the byte store. The ring size in use is 2^size_log2
// (clamped to 1..INDEX_BITS) and one slot always stays empty. Writing
// size_log2 empties the ring; write it only when no request is in flight.
// The store needs no clearing after reset: peeks only reach written bytes.
module byte_ring_buffer_core
	import brb_pkg::*;
#(
	parameter int INDEX_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// Requests
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] data_byte, [18:8] run_length, [28:19] peek_offset,
	// [39:29] advance_count
	input  logic [39:0] s_tdata,
	// [1:0] req_type, [2] run_first
	input  logic [2:0]  s_tuser,
	// Results
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_byte, [17:8] data_count, [27:18] contiguous_count,
	// [37:28] free_count, [39:38] zero
	output logic [39:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser,
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IB = INDEX_BITS;
	// Comparison width: holds ring size and the widest request field
	localparam int CW = (IB + 1 > RLEN_W) ? IB + 1 : RLEN_W;

	// Control and pointer registers
	logic [SIZE_W-1:0] size_log2_q;
	logic [IB-1:0]     head_q;
	logic [IB-1:0]     tail_q;
	logic              run_acc_q;

	// Input register
	logic              valid_s1;
	req_t              req_s1;
	logic              first_s1;
	logic [BYTE_W-1:0] dbyte_s1;
	logic [RLEN_W-1:0] rlen_s1;
	logic [POFF_W-1:0] poff_s1;
	logic [ADV_W-1:0]  adv_s1;

	// Result register
	logic               valid_s2;
	status_t            status_s2;
	logic               peek_ok_s2;
	logic [COUNT_W-1:0] stored_s2;
	logic [COUNT_W-1:0] span_s2;
	logic [COUNT_W-1:0] free_s2;

	logic              adv2;
	logic              move1;
	logic              cfg_wr;
	logic [4:0]        lg;
	logic [IB-1:0]     mask;
	logic [CW-1:0]     mask_cw;
	logic [CW-1:0]     size_cw;
	logic [CW-1:0]     stored_cw;
	logic [CW-1:0]     free_cw;
	logic [CW-1:0]     span_cw;
	logic [CW-1:0]     need_cw;
	logic              accept_run;
	logic [IB-1:0]     head_n;
	logic [IB-1:0]     tail_n;
	logic              run_n;
	status_t           status_n;
	logic              peek_ok_n;
	logic              wr_en;
	logic [IB-1:0]     rd_addr;
	logic [CW-1:0]     stored_n;
	logic [CW-1:0]     free_n;
	logic [CW-1:0]     span_n;
	logic [BYTE_W-1:0] rd_data;

	// Flow control: the result register moves when empty or taken
	assign adv2     = !valid_s2 || m_tready;
	assign move1    = valid_s1 && adv2;
	assign s_tready = !valid_s1 || adv2;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE_LOG2);
	assign prdata = (paddr[2] == REG_SIZE_LOG2) ? {{(32-SIZE_W){1'b0}}, size_log2_q}
	                                            : 32'd0;

	// Ring mask from the clamped size register
	always_comb begin
		lg = {1'b0, size_log2_q};
		if (lg == 5'd0) begin
			lg = 5'd1;
		end
		if (32'(lg) > IB) begin
			lg = 5'(IB);
		end
		mask = ~({IB{1'b1}} << lg);
	end

	assign mask_cw = CW'(mask);
	assign size_cw = mask_cw + CW'(1);

	// Fill counts before the step
	always_comb begin
		stored_cw = CW'((tail_q - head_q) & mask);
		free_cw   = mask_cw - stored_cw;
		if (tail_q >= head_q) begin
			span_cw = CW'(tail_q) - CW'(head_q);
		end else begin
			span_cw = size_cw - CW'(head_q);
		end
		need_cw = (rlen_s1 == '0) ? CW'(1) : CW'(rlen_s1);
	end

	// Request evaluation
	always_comb begin
		head_n     = head_q;
		tail_n     = tail_q;
		run_n      = run_acc_q;
		status_n   = STAT_OK;
		peek_ok_n  = 1'b0;
		wr_en      = 1'b0;
		accept_run = run_acc_q;
		unique case (req_s1)
			REQ_WRITE: begin
				if (first_s1) begin
					accept_run = (free_cw >= need_cw);
				end
				if (accept_run && (free_cw != '0)) begin
					wr_en  = move1;
					tail_n = (tail_q + IB'(1)) & mask;
					run_n  = 1'b1;
				end else begin
					run_n    = 1'b0;
					status_n = STAT_OVERFLOW;
				end
			end
			REQ_PEEK: begin
				if (CW'(poff_s1) < span_cw) begin
					peek_ok_n = 1'b1;
				end else begin
					status_n = STAT_INVALID;
				end
			end
			REQ_ADVANCE: begin
				if (CW'(adv_s1) <= stored_cw) begin
					head_n = IB'((CW'(head_q) + CW'(adv_s1)) & mask_cw);
				end else begin
					status_n = STAT_INVALID;
				end
			end
			default: begin
				status_n = STAT_INVALID;
			end
		endcase
	end

	assign rd_addr = IB'((CW'(head_q) + CW'(poff_s1)) & mask_cw);

	// Fill counts after the step
	always_comb begin
		stored_n = CW'((tail_n - head_n) & mask);
		free_n   = mask_cw - stored_n;
		if (tail_n >= head_n) begin
			span_n = CW'(tail_n) - CW'(head_n);
		end else begin
			span_n = size_cw - CW'(head_n);
		end
	end

	// Byte store
	brb_ram #(
		.ADDR_W (IB)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (dbyte_s1),
		.rd_en   (move1),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Size register and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= SIZE_LOG2_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			run_acc_q   <= 1'b0;
		end else if (cfg_wr) begin
			size_log2_q <= pwdata[SIZE_W-1:0];
			head_q      <= '0;
			tail_q      <= '0;
			run_acc_q   <= 1'b0;
		end else if (move1) begin
			head_q    <= head_n;
			tail_q    <= tail_n;
			run_acc_q <= run_n;
		end
	end

	// Input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: payload captured on each transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1   <= req_t'(s_tuser[1:0]);
			first_s1 <= s_tuser[2];
			dbyte_s1 <= s_tdata[7:0];
			rlen_s1  <= s_tdata[18:8];
			poff_s1  <= s_tdata[28:19];
			adv_s1   <= s_tdata[39:29];
		end
	end

	// Result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (move1) begin
			status_s2  <= status_n;
			peek_ok_s2 <= peek_ok_n;
			stored_s2  <= stored_n[COUNT_W-1:0];
			span_s2    <= span_n[COUNT_W-1:0];
			free_s2    <= free_n[COUNT_W-1:0];
		end
	end

	// Result transfer
	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {2'b00, free_s2, span_s2, stored_s2,
	                   (peek_ok_s2 ? rd_data : {BYTE_W{1'b0}})};

endmodule

// File: dv/byte_ring_buffer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_core_test
// Self-checking bench for the byte ring buffer core. Requests are streamed in
// with random gaps and results drained with random stalls. Every result is
// compared with a local model of the ring, across several ring sizes.
// ----------------------------------------------------------------------------
module byte_ring_buffer_core_test;
	import brb_pkg::*;

	localparam int IDX_BITS = 10;
	localparam int QUIET_LIMIT = 3000;
	// The request kind that the block must refuse.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Model copies: one plans the stimulus, one checks the block.
	localparam int PLAN = 0;
	localparam int CHECK = 1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        run_first;
		logic [10:0] run_length;
		logic [9:0]  peek_offset;
		logic [10:0] advance_count;
	} ring_req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  read_byte;
		logic [9:0]  data_count;
		logic [9:0]  span_count;
		logic [9:0]  free_count;
	} ring_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [7:0] data_byte, [18:8] run_length, [28:19] peek_offset,
	// [39:29] advance_count
	logic [39:0] s_tdata = '0;
	// [1:0] req_type, [2] run_first
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] read_byte, [17:8] data_count, [27:18] contiguous_count,
	// [37:28] free_count, [39:38] zero
	logic [39:0] m_tdata;
	// [1:0] status
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Ring model state, one copy per user.
	logic [9:0]      head_ix [2] = '{10'd0, 10'd0};
	logic [9:0]      tail_ix [2] = '{10'd0, 10'd0};
	bit              run_ok [2];
	logic [7:0]      ring_mem [2][1 << IDX_BITS];
	logic [SIZE_W-1:0] size_sel = SIZE_LOG2_RESET;

	ring_req_t req_backlog [$];
	ring_res_t due_results [$];
	ring_req_t req_held = '0;
	int        send_wait = 0;
	int        stall_left = 0;
	int        quiet_cycles = 0;
	int        fault_count = 0;
	bit        idle_on = 1'b1;

	byte_ring_buffer_core #(
		.INDEX_BITS(IDX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Index mask of the ring size in use, with the size clamped to its range.
	function automatic int ring_mask();
		int lg;
		lg = size_sel;
		if (lg < 1) lg = 1;
		if (lg > IDX_BITS) lg = IDX_BITS;
		return (1 << lg) - 1;
	endfunction

	function automatic int ring_fill(int c);
		return (int'(tail_ix[c]) - int'(head_ix[c])) & ring_mask();
	endfunction

	function automatic int ring_room(int c);
		return ring_mask() - ring_fill(c);
	endfunction

	// Bytes from head up to tail or up to the end of the ring.
	function automatic int ring_span(int c);
		if (tail_ix[c] >= head_ix[c]) return int'(tail_ix[c]) - int'(head_ix[c]);
		return ring_mask() + 1 - int'(head_ix[c]);
	endfunction

	// Apply one request to a model copy and return the result it gives.
	function automatic ring_res_t ring_apply(int c, ring_req_t r);
		ring_res_t res;
		int need;
		res = '0;
		res.status = STAT_OK;
		case (r.kind)
			REQ_WRITE: begin
				if (r.run_first) begin
					need = (r.run_length == 0) ? 1 : int'(r.run_length);
					run_ok[c] = ring_room(c) >= need;
				end
				if (run_ok[c] && ring_room(c) > 0) begin
					ring_mem[c][tail_ix[c]] = r.data_byte;
					tail_ix[c] = 10'((int'(tail_ix[c]) + 1) & ring_mask());
				end else begin
					run_ok[c] = 1'b0;
					res.status = STAT_OVERFLOW;
				end
			end
			REQ_PEEK: begin
				if (int'(r.peek_offset) < ring_span(c))
					res.read_byte = ring_mem[c][10'((int'(head_ix[c])
						+ int'(r.peek_offset)) & ring_mask())];
				else
					res.status = STAT_INVALID;
			end
			REQ_ADVANCE: begin
				if (int'(r.advance_count) <= ring_fill(c))
					head_ix[c] = 10'((int'(head_ix[c]) + int'(r.advance_count)) & ring_mask());
				else
					res.status = STAT_INVALID;
			end
			default: begin
				res.status = STAT_INVALID;
			end
		endcase
		res.data_count = 10'(ring_fill(c));
		res.span_count = 10'(ring_span(c));
		res.free_count = 10'(ring_room(c));
		return res;
	endfunction

	// Gap length for either side: mostly none, sometimes short, rarely long.
	function automatic int gap_draw();
		int roll;
		if (!idle_on) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A request with every field random, the ignored ones included.
	function automatic ring_req_t noise_req();
		ring_req_t r;
		r.kind = 2'($urandom_range(0, 2));
		r.data_byte = 8'($urandom);
		r.run_first = 1'($urandom);
		r.run_length = 11'($urandom_range(0, 1024));
		r.peek_offset = 10'($urandom);
		r.advance_count = 11'($urandom_range(0, 1024));
		return r;
	endfunction

	task automatic queue_req(ring_req_t r);
		void'(ring_apply(PLAN, r));
		req_backlog.push_back(r);
	endtask

	task automatic queue_write(logic [7:0] b, bit first, int len);
		ring_req_t r;
		r = noise_req();
		r.kind = REQ_WRITE;
		r.data_byte = b;
		r.run_first = first;
		if (first) r.run_length = 11'(len);
		queue_req(r);
	endtask

	task automatic queue_peek(int off);
		ring_req_t r;
		r = noise_req();
		r.kind = REQ_PEEK;
		r.peek_offset = 10'(off);
		queue_req(r);
	endtask

	task automatic queue_advance(int n);
		ring_req_t r;
		r = noise_req();
		r.kind = REQ_ADVANCE;
		r.advance_count = 11'(n);
		queue_req(r);
	endtask

	// Mostly well-formed write runs, peeks and advances, with some noise.
	task automatic random_phase(int n);
		ring_req_t r;
		int done, pick, roll, room, len, nb, span, fill;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			roll = $urandom_range(0, 9);
			room = ring_room(PLAN);
			if (pick < 45) begin
				if (roll == 0)
					len = 0;
				else if (roll == 1 && room > 0 && room <= 40)
					len = room;
				else if (roll < 4)
					len = $urandom_range(0, 1024);
				else if (room > 0)
					len = $urandom_range(1, (room < 12) ? room : 12);
				else
					len = $urandom_range(1, 4);
				nb = (len == 0) ? 1 : len;
				// Runs longer than 40 bytes are cut short; some runs carry extra bytes.
				if (nb > 40) nb = $urandom_range(1, 4);
				if ($urandom_range(0, 9) == 0) nb += $urandom_range(1, 3);
				queue_write(8'($urandom), 1'b1, len);
				for (int k = 1; k < nb; k++)
					queue_write(8'($urandom), 1'b0, 0);
				done += nb;
			end else if (pick < 70) begin
				span = ring_span(PLAN);
				if (span > 0 && roll < 7)
					queue_peek($urandom_range(0, span - 1));
				else if (roll < 8)
					queue_peek(span);
				else
					queue_peek($urandom_range(0, 1023));
				done++;
			end else if (pick < 93) begin
				fill = ring_fill(PLAN);
				if (roll < 8)
					queue_advance($urandom_range(0, fill));
				else if (roll == 8)
					queue_advance(fill + 1);
				else
					queue_advance($urandom_range(0, 1024));
				done++;
			end else if (pick < 97) begin
				queue_write(8'($urandom), 1'b0, 0);
				done++;
			end else begin
				r = noise_req();
				r.kind = REQ_UNUSED;
				queue_req(r);
				done++;
			end
		end
	endtask

	task automatic drain_wait();
		while (req_backlog.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
	endtask

	// Write the size register over the configuration port; this empties the ring.
	task automatic load_ring_size(int value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_SIZE_LOG2, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_sel = SIZE_W'(value);
		for (int c = 0; c < 2; c++) begin
			head_ix[c] = '0;
			tail_ix[c] = '0;
			run_ok[c] = 1'b0;
		end
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// Request side: hand out queued requests and predict each accepted one.
	always @(posedge clk) begin : drive_proc
		ring_req_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				due_results.push_back(ring_apply(CHECK, req_held));
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					s_tvalid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (req_backlog.size() > 0) begin
					nxt = req_backlog.pop_front();
					req_held <= nxt;
					s_tdata <= {nxt.advance_count, nxt.peek_offset, nxt.run_length,
						nxt.data_byte};
					s_tuser <= {nxt.run_first, nxt.kind};
					s_tvalid <= 1'b1;
					send_wait <= gap_draw();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: stall at random and compare every transfer that arrives.
	always @(posedge clk) begin : watch_proc
		ring_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					fault_count++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("read_byte", want.read_byte, m_tdata[7:0]);
					check_field("data_count", want.data_count, m_tdata[17:8]);
					check_field("contiguous_count", want.span_count, m_tdata[27:18]);
					check_field("free_count", want.free_count, m_tdata[37:28]);
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				stall_left <= gap_draw();
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int phase_sizes [10] = '{3, 1, 7, 0, 2, 15, 5, 10, 4, 9};
		ring_req_t r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset size: empty ring, short runs, bad requests.
		queue_peek(0);
		queue_advance(1);
		queue_advance(0);
		r = noise_req();
		r.kind = REQ_UNUSED;
		queue_req(r);
		queue_write(8'hFF, 1'b1, 0);
		queue_write(8'h00, 1'b1, 3);
		queue_write(8'hA5, 1'b0, 0);
		queue_write(8'h5A, 1'b0, 0);
		queue_peek(0);
		queue_peek(3);
		queue_peek(4);
		queue_peek(1023);
		queue_advance(1024);
		queue_write(8'h12, 1'b1, 1024);
		queue_write(8'h34, 1'b0, 0);
		queue_advance(4);
		drain_wait();
		repeat (4) @(negedge clk);

		// Smallest ring: one byte fits, extra bytes overflow, peek after a wrap.
		load_ring_size(1);
		@(negedge clk);
		queue_write(8'h3C, 1'b1, 1);
		queue_write(8'hC3, 1'b0, 0);
		queue_advance(1);
		queue_write(8'h77, 1'b0, 0);
		queue_write(8'h88, 1'b1, 2);
		queue_write(8'h96, 1'b1, 1);
		queue_peek(0);
		queue_peek(1);
		queue_advance(1);

		// Random part over a range of ring sizes, clamped values included.
		foreach (phase_sizes[i]) begin
			drain_wait();
			repeat (4) @(negedge clk);
			load_ring_size(phase_sizes[i]);
			@(negedge clk);
			idle_on = ($urandom_range(0, 3) != 0);
			random_phase(110);
		end

		drain_wait();
		repeat (10) @(negedge clk);
		if (fault_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
